@@ src/i2cm_pkg.sv @@
// Shared types and constants for the I2C master bit engine.
// No dependencies; every other file in src refers to this package by scoped names.
package i2cm_pkg;

  localparam int unsigned DELAY_WIDTH = 16;
  localparam int unsigned CFG_WIDTH = 16;
  localparam logic [CFG_WIDTH-1:0] HALF_PERIOD_RESET = 16'd10;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_SEND  = 3'd2,
    CMD_READ  = 3'd3,
    CMD_WACK  = 3'd4,
    CMD_ACK   = 3'd5,
    CMD_NACK  = 3'd6,
    CMD_PROBE = 3'd7
  } cmd_e;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'd0,
    PH_STA_A = 5'd1,
    PH_STA_B = 5'd2,
    PH_STA_C = 5'd3,
    PH_STP_A = 5'd4,
    PH_TX_A  = 5'd5,
    PH_TX_B  = 5'd6,
    PH_TX_C  = 5'd7,
    PH_RX_A  = 5'd8,
    PH_RX_B  = 5'd9,
    PH_WA_A  = 5'd10,
    PH_WA_B  = 5'd11,
    PH_WA_C  = 5'd12,
    PH_GA_A  = 5'd13,
    PH_GA_B  = 5'd14,
    PH_GA_C  = 5'd15,
    PH_STP2  = 5'd16
  } phase_e;

  // One tick as queued between the front and the back, already decoded.
  typedef struct packed {
    logic       cmd_valid;
    cmd_e       req_type;
    logic [7:0] tx_byte;
    logic       sda_in;
    phase_e     first_phase;
  } tick_t;

  function automatic phase_e first_phase_of(cmd_e cmd);
    phase_e ph;
    case (cmd)
      CMD_START: ph = PH_STA_A;
      CMD_STOP:  ph = PH_STP_A;
      CMD_SEND:  ph = PH_TX_A;
      CMD_READ:  ph = PH_RX_A;
      CMD_WACK:  ph = PH_WA_A;
      CMD_ACK:   ph = PH_GA_A;
      CMD_NACK:  ph = PH_GA_A;
      default:   ph = PH_STP_A;
    endcase
    return ph;
  endfunction

endpackage

@@ src/i2cm_front.sv @@
// Front part: accepts tick requests, decodes the command's first phase and
// holds them in a two-entry queue for the back part. Uses i2cm_pkg.
module i2cm_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             cmd_valid_i,
  input  logic [2:0]       req_type_i,
  input  logic [7:0]       tx_byte_i,
  input  logic             sda_in_i,
  output logic             tick_valid_o,
  output i2cm_pkg::tick_t  tick_o,
  input  logic             tick_pop_i
);

  localparam int unsigned PtrW = $clog2(i2cm_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(i2cm_pkg::QUEUE_DEPTH + 1);

  i2cm_pkg::tick_t       slot_q [i2cm_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;
  i2cm_pkg::tick_t       new_tick;
  logic                  push;
  logic                  pop;

  always_comb begin
    new_tick.cmd_valid   = cmd_valid_i;
    new_tick.req_type    = i2cm_pkg::cmd_e'(req_type_i);
    new_tick.tx_byte     = tx_byte_i;
    new_tick.sda_in      = sda_in_i;
    new_tick.first_phase = i2cm_pkg::first_phase_of(i2cm_pkg::cmd_e'(req_type_i));
  end

  assign in_stall_o   = (count_q == CntW'(i2cm_pkg::QUEUE_DEPTH));
  assign push         = in_valid_i && !in_stall_o;
  assign tick_valid_o = (count_q != '0);
  assign pop          = tick_pop_i && tick_valid_o;
  assign tick_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(i2cm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(i2cm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= new_tick;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(i2cm_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("queue count did not follow a lone push");

  a_pop_needs_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> !pop)
    else $error("pop from an empty queue");

endmodule

@@ src/i2cm_back.sv @@
// Back part: the bus phase sequencer that runs one tick per cycle unless
// stalled, the delay and result registers. Uses i2cm_pkg; fed by i2cm_front.
module i2cm_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [i2cm_pkg::CFG_WIDTH-1:0] cfg_wdata_i,
  input  logic                           tick_valid_i,
  input  i2cm_pkg::tick_t                tick_i,
  output logic                           tick_pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           scl_out_o,
  output logic                           sda_out_o,
  output logic                           busy_res_o,
  output logic                           done_res_o,
  output logic [7:0]                     rx_byte_o,
  output logic                           ack_bit_o
);

  localparam int unsigned DW = i2cm_pkg::DELAY_WIDTH;

  logic [i2cm_pkg::CFG_WIDTH-1:0] half_q;
  i2cm_pkg::phase_e phase_q, phase_d, nx;
  i2cm_pkg::cmd_e   cmd_q, cmd_d;
  logic [DW-1:0]    wait_q, wait_d, dly;
  logic [3:0]       bit_q, bit_d;
  logic [7:0]       tx_q, tx_d;
  logic [7:0]       rx_q, rx_d;
  logic             scl_q, scl_d;
  logic             sda_q, sda_d;
  logic             ack_q, ack_d;
  logic             busy, done, do_enter, probe, pop;
  logic             out_valid_q;

  assign pop        = tick_valid_i && (!out_valid_q || !out_stall_i);
  assign tick_pop_o = pop;
  assign probe      = (cmd_q == i2cm_pkg::CMD_PROBE);

  // A zero setting behaves as a one-tick delay.
  always_comb begin
    dly = DW'(half_q);
    if (dly == '0) begin
      dly = DW'(1);
    end
  end

  always_comb begin
    phase_d  = phase_q;
    cmd_d    = cmd_q;
    wait_d   = wait_q;
    bit_d    = bit_q;
    tx_d     = tx_q;
    rx_d     = rx_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    ack_d    = ack_q;
    busy     = 1'b0;
    done     = 1'b0;
    do_enter = 1'b0;
    nx       = i2cm_pkg::PH_IDLE;

    if (phase_q == i2cm_pkg::PH_IDLE) begin
      if (tick_i.cmd_valid) begin
        cmd_d    = tick_i.req_type;
        tx_d     = tick_i.tx_byte;
        bit_d    = '0;
        nx       = tick_i.first_phase;
        do_enter = 1'b1;
        busy     = 1'b1;
      end
    end else begin
      wait_d = (wait_q != '0) ? wait_q - DW'(1) : wait_q;
      if (wait_d == '0) begin
        // The current step's delay has run out: close it and pick the next one.
        case (phase_q)
          i2cm_pkg::PH_STA_A: nx = i2cm_pkg::PH_STA_B;
          i2cm_pkg::PH_STA_B: nx = i2cm_pkg::PH_STA_C;
          i2cm_pkg::PH_STA_C: nx = probe ? i2cm_pkg::PH_TX_A : i2cm_pkg::PH_IDLE;
          i2cm_pkg::PH_STP_A: begin
            sda_d = 1'b1;
            nx    = probe ? i2cm_pkg::PH_STA_A : i2cm_pkg::PH_IDLE;
          end
          i2cm_pkg::PH_STP2: begin
            sda_d = 1'b1;
            nx    = i2cm_pkg::PH_IDLE;
          end
          i2cm_pkg::PH_TX_A: nx = i2cm_pkg::PH_TX_B;
          i2cm_pkg::PH_TX_B: nx = i2cm_pkg::PH_TX_C;
          i2cm_pkg::PH_TX_C: begin
            tx_d  = {tx_q[6:0], 1'b0};
            bit_d = bit_q + 4'd1;
            if (!bit_d[3]) begin
              nx = i2cm_pkg::PH_TX_A;
            end else begin
              nx = probe ? i2cm_pkg::PH_WA_A : i2cm_pkg::PH_IDLE;
            end
          end
          i2cm_pkg::PH_RX_A: begin
            rx_d = {rx_q[6:0], tick_i.sda_in};
            nx   = i2cm_pkg::PH_RX_B;
          end
          i2cm_pkg::PH_RX_B: begin
            bit_d = bit_q + 4'd1;
            nx    = !bit_d[3] ? i2cm_pkg::PH_RX_A : i2cm_pkg::PH_IDLE;
          end
          i2cm_pkg::PH_WA_A: nx = i2cm_pkg::PH_WA_B;
          i2cm_pkg::PH_WA_B: begin
            ack_d = tick_i.sda_in;
            nx    = i2cm_pkg::PH_WA_C;
          end
          i2cm_pkg::PH_WA_C: nx = probe ? i2cm_pkg::PH_STP2 : i2cm_pkg::PH_IDLE;
          i2cm_pkg::PH_GA_A: nx = i2cm_pkg::PH_GA_B;
          i2cm_pkg::PH_GA_B: nx = i2cm_pkg::PH_GA_C;
          i2cm_pkg::PH_GA_C: begin
            if (cmd_q == i2cm_pkg::CMD_ACK) begin
              sda_d = 1'b1;
            end
            nx = i2cm_pkg::PH_IDLE;
          end
          default: nx = i2cm_pkg::PH_IDLE;
        endcase
        if (nx == i2cm_pkg::PH_IDLE) begin
          phase_d = i2cm_pkg::PH_IDLE;
          wait_d  = '0;
          done    = 1'b1;
        end else begin
          do_enter = 1'b1;
          busy     = 1'b1;
        end
      end else begin
        busy = 1'b1;
      end
    end

    // Entering a step sets its line drives and restarts the delay.
    if (do_enter) begin
      phase_d = nx;
      wait_d  = dly;
      case (nx)
        i2cm_pkg::PH_STA_A: begin
          sda_d = 1'b1;
          scl_d = 1'b1;
        end
        i2cm_pkg::PH_STA_B: sda_d = 1'b0;
        i2cm_pkg::PH_STA_C: scl_d = 1'b0;
        i2cm_pkg::PH_STP_A, i2cm_pkg::PH_STP2: begin
          sda_d = 1'b0;
          scl_d = 1'b1;
        end
        i2cm_pkg::PH_TX_A: sda_d = tx_d[7];
        i2cm_pkg::PH_TX_B: scl_d = 1'b1;
        i2cm_pkg::PH_TX_C: begin
          scl_d = 1'b0;
          if (bit_d == 4'd7) begin
            sda_d = 1'b1;
          end
        end
        i2cm_pkg::PH_RX_A: scl_d = 1'b1;
        i2cm_pkg::PH_RX_B: scl_d = 1'b0;
        i2cm_pkg::PH_WA_A: sda_d = 1'b1;
        i2cm_pkg::PH_WA_B: scl_d = 1'b1;
        i2cm_pkg::PH_WA_C: scl_d = 1'b0;
        i2cm_pkg::PH_GA_A: sda_d = (cmd_d == i2cm_pkg::CMD_ACK) ? 1'b0 : 1'b1;
        i2cm_pkg::PH_GA_B: scl_d = 1'b1;
        i2cm_pkg::PH_GA_C: scl_d = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= i2cm_pkg::HALF_PERIOD_RESET;
    end else if (cfg_we_i) begin
      half_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= i2cm_pkg::PH_IDLE;
      cmd_q   <= i2cm_pkg::CMD_START;
      wait_q  <= '0;
      bit_q   <= '0;
      tx_q    <= '0;
      rx_q    <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      ack_q   <= 1'b0;
    end else if (pop) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      wait_q  <= wait_d;
      bit_q   <= bit_d;
      tx_q    <= tx_d;
      rx_q    <= rx_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      ack_q   <= ack_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= tick_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      scl_out_o  <= scl_d;
      sda_out_o  <= sda_d;
      busy_res_o <= busy;
      done_res_o <= done;
      rx_byte_o  <= rx_d;
      ack_bit_o  <= ack_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && done) |=> (phase_q == i2cm_pkg::PH_IDLE))
    else $error("completion did not return the engine to idle");

  a_wait_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != i2cm_pkg::PH_IDLE) |-> (wait_q != '0))
    else $error("active step with an empty delay count");

  a_bit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != i2cm_pkg::PH_IDLE) |-> (bit_q <= 4'd8))
    else $error("bit counter ran past a byte");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop |=> ($stable(phase_q) && $stable(wait_q)))
    else $error("engine state moved without a request");

endmodule

@@ src/i2c_master_bit_engine_unit.sv @@
// Top level of the I2C master bit engine: joins the request queue and the
// phase sequencer. Uses i2cm_pkg, i2cm_front and i2cm_back.
//
// Each request is one bus tick carrying an optional command and the sampled
// SDA level; each one yields exactly one result with the SCL/SDA drives,
// busy/done flags, the receive shift register and the last ACK bit. One
// request is taken per clock cycle while the input is not stalled. A request
// is written into the two-entry request queue and is then stepped by the
// single-step phase sequencer into the result register. While a result is
// held off, two more requests fit in the queue before the input stalls. Every
// bus step lasts the value written to the delay register (reset value ten
// ticks; zero acts as one). Commands offered while a command runs, or on its
// completion tick, are ignored.
module i2c_master_bit_engine_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [i2cm_pkg::CFG_WIDTH-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           cmd_valid_i,
  input  logic [2:0]                     req_type_i,
  input  logic [7:0]                     tx_byte_i,
  input  logic                           sda_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           scl_out_o,
  output logic                           sda_out_o,
  output logic                           busy_res_o,
  output logic                           done_res_o,
  output logic [7:0]                     rx_byte_o,
  output logic                           ack_bit_o
);

  logic            tick_valid;
  logic            tick_pop;
  i2cm_pkg::tick_t tick;

  i2cm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_valid_i  (cmd_valid_i),
    .req_type_i   (req_type_i),
    .tx_byte_i    (tx_byte_i),
    .sda_in_i     (sda_in_i),
    .tick_valid_o (tick_valid),
    .tick_o       (tick),
    .tick_pop_i   (tick_pop)
  );

  i2cm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .tick_valid_i (tick_valid),
    .tick_i       (tick),
    .tick_pop_o   (tick_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .scl_out_o    (scl_out_o),
    .sda_out_o    (sda_out_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .rx_byte_o    (rx_byte_o),
    .ack_bit_o    (ack_bit_o)
  );

endmodule
